// ===== rtl/button_click_classifier_assert.svh =====
// Assertion macros for the button click classifier checker.
// Used by bcc_checker.sv; it needs no other file.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("button click classifier check failed");

// When the antecedent holds, the consequent must hold on the next edge.
`define BCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button click classifier sequence check failed");

`endif

// ===== rtl/bcc_pkg.sv =====
// Shared types and constants of the button click classifier.
// No dependencies; the top level, bcc_csr and bcc_step refer to it by scoped names.
package bcc_pkg;

   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int COUNT_W = 8;
   localparam int KIND_W  = 3;
   localparam int INDEX_W = 2;

   // Click kind codes.
   localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TRIPLE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FOUR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIVE   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TEN    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LONG   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd7;

   // Click count that resolves as the ten-click kind.
   localparam logic [COUNT_W-1:0] TEN_CLICKS = 8'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_LONG      = 2'd1;
   localparam logic [INDEX_W-1:0] REG_GAP       = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_W-1:0] LONG_RESET     = 16'd250;
   localparam logic [CFG_W-1:0] GAP_RESET      = 16'd300;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_len;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] multi_click_gap_ms;
   } cfg_type;

   // Packed so that the last field lands in the lowest bits.
   typedef struct packed {
      logic [TIME_W-1:0]  held_ms;
      logic [KIND_W-1:0]  last_kind;
      logic [COUNT_W-1:0] click_total;
      logic               is_down;
      logic [KIND_W-1:0]  click_kind;
      logic               click_event;
      logic               changed_event;
      logic               released_event;
      logic               pressed_event;
   } result_type;

endpackage

// ===== rtl/button_click_classifier.sv =====
// Button click classifier: one poll in, one event word out, one poll per cycle
// while the response is not stalled; each request is registered in the input
// stage, then its result in the output stage; detector state updates per step.
// Synchronous active-high reset clears the detector state, the registers to
// their defaults and both pipeline stages; it needs no clearing pass.
module button_click_classifier (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,   // [0] pressed_event, [1] released_event,
                                      // [2] changed_event, [3] click_event,
                                      // [6:4] click_kind, [7] is_down,
                                      // [15:8] click_total, [18:16] last_kind,
                                      // [50:19] held_ms, rest zero
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);

   localparam int RESULT_W = $bits(bcc_pkg::result_type);

   logic                         in_vld_ff, in_vld_in;
   logic                         pin_ff;
   logic [bcc_pkg::TIME_W-1:0]   now_ff;
   logic                         out_vld_ff, out_vld_in;
   bcc_pkg::result_type          out_ff;
   bcc_pkg::result_type          step_result;
   bcc_pkg::cfg_type             cfg;
   logic                         advance;
   logic                         step_en;
   logic                         req_take;

   assign csr_ready = 1'b1;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The output stage can take a new result when empty or being drained.
   assign advance    = !out_vld_ff || rsp_tready;
   assign step_en    = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = step_en || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pin_ff <= req_tdata[0];
         now_ff <= req_tdata[bcc_pkg::TIME_W:1];
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   bcc_step u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .pin_level (pin_ff),
      .now_ms    (now_ff),
      .cfg       (cfg),
      .result    (step_result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(56-RESULT_W){1'b0}}, out_ff};

endmodule

// ===== rtl/bcc_csr.sv =====
// Configuration registers of the button click classifier.
// Depends on bcc_pkg for widths, register indexes and reset values.
module bcc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [bcc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [bcc_pkg::CFG_W-1:0]     csr_data,
   output bcc_pkg::cfg_type              cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bcc_pkg::REG_DEBOUNCE: cfg_in.debounce_len       = csr_data;
            bcc_pkg::REG_LONG:     cfg_in.long_press_ms      = csr_data;
            bcc_pkg::REG_GAP:      cfg_in.multi_click_gap_ms = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_len       <= bcc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms      <= bcc_pkg::LONG_RESET;
         cfg_ff.multi_click_gap_ms <= bcc_pkg::GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bcc_step.sv =====
// Click detector state and the per-poll update logic.
// Depends on bcc_pkg; fed by the input register of the top level.
module bcc_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic                          pin_level,
   input  logic [bcc_pkg::TIME_W-1:0]    now_ms,
   input  bcc_pkg::cfg_type              cfg,
   output bcc_pkg::result_type           result
);

   logic                          level_ff, level_in;
   logic [bcc_pkg::TIME_W-1:0]    press_start_ff, press_start_in;
   logic [bcc_pkg::TIME_W-1:0]    last_hold_ff, last_hold_in;
   logic [bcc_pkg::TIME_W-1:0]    click_start_ff, click_start_in;
   logic [bcc_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          reported_ff, reported_in;
   logic                          long_ff, long_in;
   logic [bcc_pkg::KIND_W-1:0]    kind_seen_ff, kind_seen_in;

   logic [bcc_pkg::TIME_W-1:0]    press_age;
   logic [bcc_pkg::TIME_W-1:0]    click_age;
   logic [bcc_pkg::TIME_W-1:0]    debounce_w, long_w, gap_w;
   logic                          pressed, released, clicked;
   logic [bcc_pkg::KIND_W-1:0]    kind;

   assign debounce_w = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, cfg.debounce_len};
   assign long_w     = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, cfg.long_press_ms};
   assign gap_w      = {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, cfg.multi_click_gap_ms};

   // Differences wrap modulo the timestamp width.
   assign press_age = now_ms - press_start_ff;
   assign click_age = now_ms - click_start_ff;

   always_comb begin
      level_in       = pin_level;
      press_start_in = press_start_ff;
      last_hold_in   = last_hold_ff;
      click_start_in = click_start_ff;
      count_in       = count_ff;
      reported_in    = reported_ff;
      long_in        = long_ff;
      kind_seen_in   = kind_seen_ff;
      pressed        = 1'b0;
      released       = 1'b0;
      clicked        = 1'b0;
      kind           = bcc_pkg::KIND_SINGLE;

      if (level_ff && !pin_level) begin
         // Falling edge: a new press and one more click.
         press_start_in = now_ms;
         reported_in    = 1'b0;
         if (count_ff != bcc_pkg::COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         click_start_in = now_ms;
      end else if (!level_ff && pin_level) begin
         last_hold_in = press_age;
         if (press_age >= debounce_w) begin
            released = 1'b1;
            if (press_age >= long_w) begin
               long_in = 1'b1;
            end
         end
      end else if (!pin_level && !reported_ff && (press_age >= debounce_w)) begin
         pressed     = 1'b1;
         reported_in = 1'b1;
      end else if (pin_level && (click_age > gap_w)) begin
         if (long_ff) begin
            // A long click counts only when it is the whole sequence.
            if (count_ff == 8'd1) begin
               clicked = 1'b1;
               kind    = bcc_pkg::KIND_LONG;
            end
            long_in = 1'b0;
         end else begin
            case (count_ff)
               8'd1: begin clicked = 1'b1; kind = bcc_pkg::KIND_SINGLE; end
               8'd2: begin clicked = 1'b1; kind = bcc_pkg::KIND_DOUBLE; end
               8'd3: begin clicked = 1'b1; kind = bcc_pkg::KIND_TRIPLE; end
               8'd4: begin clicked = 1'b1; kind = bcc_pkg::KIND_FOUR;   end
               8'd5: begin clicked = 1'b1; kind = bcc_pkg::KIND_FIVE;   end
               bcc_pkg::TEN_CLICKS: begin
                  clicked = 1'b1;
                  kind    = bcc_pkg::KIND_TEN;
               end
               default: begin
                  clicked = 1'b0;
                  kind    = bcc_pkg::KIND_SINGLE;
               end
            endcase
         end
         if (clicked) begin
            kind_seen_in = kind;
         end
         count_in       = '0;
         click_start_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 1'b1;
         press_start_ff <= '0;
         last_hold_ff   <= '0;
         click_start_ff <= '0;
         count_ff       <= '0;
         reported_ff    <= 1'b0;
         long_ff        <= 1'b0;
         kind_seen_ff   <= bcc_pkg::KIND_NONE;
      end else if (step_en) begin
         level_ff       <= level_in;
         press_start_ff <= press_start_in;
         last_hold_ff   <= last_hold_in;
         click_start_ff <= click_start_in;
         count_ff       <= count_in;
         reported_ff    <= reported_in;
         long_ff        <= long_in;
         kind_seen_ff   <= kind_seen_in;
      end
   end

   always_comb begin
      result.pressed_event  = pressed;
      result.released_event = released;
      result.changed_event  = pressed | released;
      result.click_event    = clicked;
      result.click_kind     = kind;
      result.is_down        = ~pin_level;
      result.click_total    = count_in;
      result.last_kind      = kind_seen_in;
      result.held_ms        = last_hold_in;
   end

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level checks of the button click classifier, bound to the top level.
// Depends on button_click_classifier_assert.svh for the assertion macros.
`include "button_click_classifier_assert.svh"

module bcc_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [55:0]   rsp_tdata
);

   // A stalled response stays offered.
   `BCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // The changed flag is exactly the union of the press and release flags.
   `BCC_ASSERT_ALWAYS(a_changed, clock, reset, !rsp_tvalid || (rsp_tdata[2] == (rsp_tdata[0] | rsp_tdata[1])))

   // A resolved kind is recorded as the last kind; with no event the kind is zero.
   `BCC_ASSERT_ALWAYS(a_kind, clock, reset, !rsp_tvalid || (rsp_tdata[3] ? (rsp_tdata[18:16] == rsp_tdata[6:4]) : (rsp_tdata[6:4] == 3'd0)))

   // A press event only fires while the button is down, a release only when up.
   `BCC_ASSERT_ALWAYS(a_level, clock, reset, !rsp_tvalid || ((!rsp_tdata[0] || rsp_tdata[7]) && (!rsp_tdata[1] || !rsp_tdata[7])))

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
